// ===== design/rv32_pkg.sv =====
// shared opcodes and constants for the rv32im execute block
package rv32_pkg;

  localparam int unsigned DataRamBytes = 16384;
  localparam int unsigned RamAw = $clog2(DataRamBytes);
  localparam int unsigned RowAw = RamAw - 2;
  localparam int unsigned RamRows = DataRamBytes / 4;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [31:0] InstEbreak = 32'h0010_0073;
  localparam logic [31:0] InstEcall  = 32'h0000_0073;
  localparam logic [31:0] InstMret   = 32'h3020_0073;

  localparam logic [11:0] CsrMstatus   = 12'h300;
  localparam logic [11:0] CsrMtvec     = 12'h305;
  localparam logic [11:0] CsrMepc      = 12'h341;
  localparam logic [11:0] CsrMcause    = 12'h342;
  localparam logic [11:0] CsrMvendorid = 12'hf11;
  localparam logic [11:0] CsrMarchid   = 12'hf12;
  localparam logic [31:0] CauseEcallM  = 32'd11;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StHalt    = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;
  localparam logic [1:0] StBadCsr  = 2'd3;

  localparam int unsigned QDepth = 2;

endpackage

// ===== design/rv32_front.sv =====
// front end: instruction queue that buffers fetched instruction beats
module rv32_front import rv32_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full,
  input  logic [31:0] instruction_i,
  output logic        inst_valid_o,
  input  logic        inst_take_i,
  output logic [31:0] inst_o
);

  logic [31:0] mem_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full         = (cnt_q == 2'(QDepth));
  assign inst_valid_o = (cnt_q != 2'd0);
  assign inst_o       = mem_q[rp_q];
  assign do_push      = push_i && !full;
  assign do_pop       = inst_take_i && inst_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= instruction_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== design/rv32_divider.sv =====
// iterative unsigned divider, one quotient bit per cycle
module rv32_divider import rv32_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic [31:0] q_q, r_q, d_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {r_q, q_q[31]};
  assign trial   = shifted - {1'b0, d_q};
  assign done_o  = busy_q && (cnt_q == 6'd0);
  assign quot_o  = q_q;
  assign rem_o   = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 6'd32;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q && cnt_q != 6'd0) begin
      if (!trial[32]) begin
        r_q <= trial[31:0];
        q_q <= {q_q[30:0], 1'b1};
      end else begin
        r_q <= shifted[31:0];
        q_q <= {q_q[30:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/rv32_back.sv =====
// back end: sequencer that executes one instruction and writes one result beat
module rv32_back import rv32_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        inst_valid_i,
  input  logic [31:0] inst_i,
  output logic        inst_take_o,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] next_pc_o,
  output logic        reg_write_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic [1:0]  status_o,
  output logic [31:0] exit_value_o
);

  typedef enum logic [3:0] {
    SClear, SIdle, SRead, SExec, SMul, SDivWait, SDivFix, SLoad, SStore, SDone
  } state_e;

  state_e      state_q;
  logic [31:0] inst_q, pc_q, a_q, b_q, a0_q;
  logic [31:0] regs_q [32];
  logic [31:0] mstatus_q, mtvec_q, mepc_q, mcause_q, mvendor_q, march_q;
  logic [RowAw-1:0] clr_q;

  // result register
  logic        out_v_q;
  logic [31:0] npc_q, val_q, exitv_q;
  logic        wb_q;
  logic [4:0]  rdo_q;
  logic [1:0]  st_q;

  // memory access sequencing
  logic [31:0] addr_q;
  logic [2:0]  bidx_q, blen_q;
  logic [31:0] ldv_q;
  logic [63:0] prod_q;

  // data ram as 4 byte lanes; bytewise access one byte per cycle
  logic [7:0] ram0 [RamRows];
  logic [7:0] ram1 [RamRows];
  logic [7:0] ram2 [RamRows];
  logic [7:0] ram3 [RamRows];
  logic [7:0] rdat_q;

  logic [6:0] op;
  logic [4:0] rd, rs1, rs2;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [31:0] immi, imms, immb, immj, immu;
  assign op = inst_q[6:0];
  assign rd = inst_q[11:7];
  assign f3 = inst_q[14:12];
  assign rs1 = inst_q[19:15];
  assign rs2 = inst_q[24:20];
  assign f7 = inst_q[31:25];
  assign immi = {{20{inst_q[31]}}, inst_q[31:20]};
  assign imms = {{20{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
  assign immb = {{19{inst_q[31]}}, inst_q[31], inst_q[7], inst_q[30:25], inst_q[11:8], 1'b0};
  assign immj = {{11{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20], inst_q[30:21], 1'b0};
  assign immu = {inst_q[31:12], 12'h000};

  // byte address for current bytewise step
  logic [31:0]      baddr;
  logic [RamAw-1:0] bidx_ram;
  logic [RowAw-1:0] brow;
  logic [1:0]       blane;
  assign baddr = addr_q + 32'(bidx_q);
  assign bidx_ram = baddr[RamAw-1:0];
  assign brow = bidx_ram[RamAw-1:2];
  assign blane = bidx_ram[1:0];

  // divider
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q, div_r;
  logic        na, nb;
  assign na = a_q[31] && !f3[0];
  assign nb = b_q[31] && !f3[0];
  assign div_a = na ? (32'd0 - a_q) : a_q;
  assign div_b = nb ? (32'd0 - b_q) : b_q;

  rv32_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  // execute combinational result
  logic [31:0] ex_val, ex_npc, ex_exit, csr_old;
  logic        ex_wb, ex_mul, ex_div, ex_load, ex_store, csr_hit, br_t, br_ok;
  logic [1:0]  ex_st;
  logic [31:0] opb;
  logic [4:0]  sh;

  always_comb begin
    csr_hit = 1'b1;
    case (inst_q[31:20])
      CsrMstatus:   csr_old = mstatus_q;
      CsrMtvec:     csr_old = mtvec_q;
      CsrMepc:      csr_old = mepc_q;
      CsrMcause:    csr_old = mcause_q;
      CsrMvendorid: csr_old = mvendor_q;
      CsrMarchid:   csr_old = march_q;
      default: begin
        csr_old = '0;
        csr_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    br_ok = 1'b1;
    case (f3)
      3'd0: br_t = a_q == b_q;
      3'd1: br_t = a_q != b_q;
      3'd4: br_t = $signed(a_q) < $signed(b_q);
      3'd5: br_t = !($signed(a_q) < $signed(b_q));
      3'd6: br_t = a_q < b_q;
      3'd7: br_t = a_q >= b_q;
      default: begin
        br_t = 1'b0;
        br_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ex_val = '0;
    ex_npc = pc_q + 32'd4;
    ex_exit = '0;
    ex_wb = 1'b0;
    ex_st = StOk;
    ex_mul = 1'b0;
    ex_div = 1'b0;
    ex_load = 1'b0;
    ex_store = 1'b0;
    opb = (op == OpImm) ? immi : b_q;
    sh = (op == OpImm) ? rs2 : b_q[4:0];
    case (op)
      OpLui: begin
        ex_wb = 1'b1;
        ex_val = immu;
      end
      OpAuipc: begin
        ex_wb = 1'b1;
        ex_val = pc_q + immu;
      end
      OpJal: begin
        ex_wb = 1'b1;
        ex_val = pc_q + 32'd4;
        ex_npc = pc_q + immj;
      end
      OpJalr: begin
        if (f3 != 3'd0) ex_st = StInvalid;
        else begin
          ex_wb = 1'b1;
          ex_val = pc_q + 32'd4;
          ex_npc = (a_q + immi) & ~32'h1;
        end
      end
      OpBranch: begin
        if (!br_ok) ex_st = StInvalid;
        else if (br_t) ex_npc = pc_q + immb;
      end
      OpLoad: begin
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ex_st = StInvalid;
        else ex_load = 1'b1;
      end
      OpStore: begin
        if (f3 > 3'd2) ex_st = StInvalid;
        else ex_store = 1'b1;
      end
      OpImm, OpReg: begin
        ex_wb = 1'b1;
        if (op == OpReg && f7 == 7'h01) begin
          if (f3[2]) ex_div = 1'b1;
          else ex_mul = 1'b1;
        end else if (op == OpReg && f7 == 7'h20 && f3 == 3'd0) begin
          ex_val = a_q - b_q;
        end else if (op == OpReg && f7 != 7'h00 && !(f7 == 7'h20 && f3 == 3'd5)) begin
          ex_wb = 1'b0;
          ex_st = StInvalid;
        end else begin
          case (f3)
            3'd0: ex_val = a_q + opb;
            3'd1: begin
              if (op == OpImm && f7 != 7'h00) begin
                ex_wb = 1'b0;
                ex_st = StInvalid;
              end else ex_val = a_q << sh;
            end
            3'd2: ex_val = {31'd0, $signed(a_q) < $signed(opb)};
            3'd3: ex_val = {31'd0, a_q < opb};
            3'd4: ex_val = a_q ^ opb;
            3'd5: begin
              if (f7 == 7'h00) ex_val = a_q >> sh;
              else if (f7 == 7'h20) ex_val = 32'($signed(a_q) >>> sh);
              else begin
                ex_wb = 1'b0;
                ex_st = StInvalid;
              end
            end
            3'd6: ex_val = a_q | opb;
            default: ex_val = a_q & opb;
          endcase
        end
      end
      OpSystem: begin
        if (inst_q == InstEbreak) begin
          ex_st = StHalt;
          ex_exit = a0_q;
        end else if (inst_q == InstEcall) begin
          ex_npc = mtvec_q;
        end else if (inst_q == InstMret) begin
          ex_npc = mepc_q;
        end else if (f3 == 3'd1 || f3 == 3'd2) begin
          if (!csr_hit) ex_st = StBadCsr;
          else begin
            ex_wb = 1'b1;
            ex_val = csr_old;
          end
        end else ex_st = StInvalid;
      end
      default: ex_st = StInvalid;
    endcase
    if (ex_st == StInvalid || ex_st == StBadCsr) ex_npc = pc_q;
  end

  // 33x33 signed product covers the signed, mixed and unsigned forms
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign ma = $signed({(f3 == 3'd1 || f3 == 3'd2) && a_q[31], a_q});
  assign mb = $signed({(f3 == 3'd1) && b_q[31], b_q});
  assign mp = ma * mb;

  logic [31:0] div_res;
  always_comb begin
    if (b_q == 32'd0) div_res = f3[1] ? a_q : 32'hffff_ffff;
    else if (!f3[0] && b_q == 32'hffff_ffff) div_res = f3[1] ? 32'd0 : (32'd0 - a_q);
    else if (f3[1]) div_res = na ? (32'd0 - div_r) : div_r;
    else div_res = (na != nb) ? (32'd0 - div_q) : div_q;
  end

  logic [2:0] ld_len;
  always_comb begin
    case (f3[1:0])
      2'd0: ld_len = 3'd1;
      2'd1: ld_len = 3'd2;
      default: ld_len = 3'd4;
    endcase
  end

  // load value with the byte read last cycle merged in
  logic [31:0] ld_raw;
  always_comb begin
    ld_raw = ldv_q;
    case (bidx_q)
      3'd1: ld_raw[7:0] = rdat_q;
      3'd2: ld_raw[15:8] = rdat_q;
      3'd3: ld_raw[23:16] = rdat_q;
      3'd4: ld_raw[31:24] = rdat_q;
      default: ld_raw = ldv_q;
    endcase
  end

  logic [31:0] ld_final;
  always_comb begin
    case (f3)
      3'd0: ld_final = {{24{ld_raw[7]}}, ld_raw[7:0]};
      3'd1: ld_final = {{16{ld_raw[15]}}, ld_raw[15:0]};
      3'd4: ld_final = {24'd0, ld_raw[7:0]};
      3'd5: ld_final = {16'd0, ld_raw[15:0]};
      default: ld_final = ld_raw;
    endcase
  end

  logic [7:0] st_byte;
  always_comb begin
    case (bidx_q[1:0])
      2'd0: st_byte = b_q[7:0];
      2'd1: st_byte = b_q[15:8];
      2'd2: st_byte = b_q[23:16];
      default: st_byte = b_q[31:24];
    endcase
  end

  logic ram_we;
  logic [RowAw-1:0] ram_row;
  logic [7:0] ram_wd;
  assign ram_we = (state_q == SClear) || (state_q == SStore);
  assign ram_row = (state_q == SClear) ? clr_q : brow;
  assign ram_wd = (state_q == SClear) ? 8'd0 : st_byte;

  always_ff @(posedge clk_i) begin
    if (ram_we && (state_q == SClear || blane == 2'd0)) ram0[ram_row] <= ram_wd;
    if (ram_we && (state_q == SClear || blane == 2'd1)) ram1[ram_row] <= ram_wd;
    if (ram_we && (state_q == SClear || blane == 2'd2)) ram2[ram_row] <= ram_wd;
    if (ram_we && (state_q == SClear || blane == 2'd3)) ram3[ram_row] <= ram_wd;
    case (blane)
      2'd0: rdat_q <= ram0[brow];
      2'd1: rdat_q <= ram1[brow];
      2'd2: rdat_q <= ram2[brow];
      default: rdat_q <= ram3[brow];
    endcase
  end

  assign div_start = (state_q == SExec) && ex_div;
  assign inst_take_o = (state_q == SIdle) && inst_valid_i && !out_v_q;
  assign empty = !out_v_q;
  assign next_pc_o = npc_q;
  assign reg_write_o = wb_q;
  assign reg_index_o = rdo_q;
  assign reg_value_o = val_q;
  assign status_o = st_q;
  assign exit_value_o = exitv_q;

  logic        fin;
  logic [31:0] fin_val;
  logic        fin_wb;
  always_comb begin
    fin = 1'b0;
    fin_val = ex_val;
    fin_wb = ex_wb;
    case (state_q)
      SExec: fin = !(ex_mul || ex_div || ex_load || ex_store);
      SMul: begin
        fin = 1'b1;
        fin_val = (f3 == 3'd0) ? prod_q[31:0] : prod_q[63:32];
      end
      SDivFix: begin
        fin = 1'b1;
        fin_val = div_res;
      end
      SLoad: begin
        fin = (bidx_q == blen_q);
        fin_val = ld_final;
        fin_wb = 1'b1;
      end
      SStore: begin
        fin = (bidx_q + 3'd1 == blen_q);
        fin_wb = 1'b0;
      end
      default: fin = 1'b0;
    endcase
    if (rd == 5'd0) fin_wb = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SMul || (state_q == SExec && ex_mul)) prod_q <= mp[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q <= '0;
      out_v_q <= 1'b0;
      pc_q <= '0;
      for (int i = 0; i < 32; i++) regs_q[i] <= '0;
      mstatus_q <= '0;
      mtvec_q <= '0;
      mepc_q <= '0;
      mcause_q <= '0;
      mvendor_q <= '0;
      march_q <= '0;
      inst_q <= '0;
      a_q <= '0;
      b_q <= '0;
      a0_q <= '0;
      npc_q <= '0;
      val_q <= '0;
      exitv_q <= '0;
      wb_q <= 1'b0;
      rdo_q <= '0;
      st_q <= StOk;
      addr_q <= '0;
      bidx_q <= '0;
      blen_q <= '0;
      ldv_q <= '0;
    end else begin
      if (pop && out_v_q) out_v_q <= 1'b0;
      case (state_q)
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == RowAw'(RamRows - 1)) state_q <= SIdle;
        end
        SIdle: begin
          if (inst_take_o) begin
            inst_q <= inst_i;
            state_q <= SRead;
          end
        end
        SRead: begin
          a_q <= regs_q[rs1];
          b_q <= regs_q[rs2];
          a0_q <= regs_q[10];
          state_q <= SExec;
        end
        SExec: begin
          bidx_q <= '0;
          if (ex_load) begin
            addr_q <= a_q + immi;
            blen_q <= ld_len;
            ldv_q <= '0;
            state_q <= SLoad;
          end else if (ex_store) begin
            addr_q <= a_q + imms;
            blen_q <= ld_len;
            state_q <= SStore;
          end else if (ex_mul) state_q <= SMul;
          else if (ex_div) state_q <= SDivWait;
          else state_q <= SDone;
          if (ex_st == StOk && op == OpSystem) begin
            if (inst_q == InstEcall) begin
              mepc_q <= pc_q;
              mcause_q <= CauseEcallM;
            end else if (inst_q != InstMret && inst_q != InstEbreak && csr_hit) begin
              case (inst_q[31:20])
                CsrMstatus:   mstatus_q <= f3[0] ? a_q : (mstatus_q | a_q);
                CsrMtvec:     mtvec_q <= f3[0] ? a_q : (mtvec_q | a_q);
                CsrMepc:      mepc_q <= f3[0] ? a_q : (mepc_q | a_q);
                CsrMcause:    mcause_q <= f3[0] ? a_q : (mcause_q | a_q);
                CsrMvendorid: mvendor_q <= f3[0] ? a_q : (mvendor_q | a_q);
                default:      march_q <= f3[0] ? a_q : (march_q | a_q);
              endcase
            end
          end
        end
        SDivWait: if (div_done) state_q <= SDivFix;
        SLoad: begin
          // read of byte bidx-1 lands in rdat this cycle
          ldv_q <= ld_raw;
          bidx_q <= bidx_q + 3'd1;
          if (bidx_q == blen_q) state_q <= SDone;
        end
        SStore: begin
          bidx_q <= bidx_q + 3'd1;
          if (fin) state_q <= SDone;
        end
        SMul, SDivFix: state_q <= SDone;
        SDone: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
      if (fin) begin
        out_v_q <= 1'b1;
        npc_q <= ex_npc;
        pc_q <= ex_npc;
        wb_q <= fin_wb;
        rdo_q <= fin_wb ? rd : 5'd0;
        val_q <= fin_wb ? fin_val : 32'd0;
        st_q <= ex_st;
        exitv_q <= ex_exit;
        if (fin_wb) regs_q[rd] <= fin_val;
      end
    end
  end

endmodule

// ===== design/rv32im_instruction_execute.sv =====
// rv32im execute block: instruction queue front end and multicycle execute back end
// sequence per instruction: register read, execute, then a multiply, divider or bytewise
//   load/store step (one ram byte per cycle) where needed, and a done state before idle
// flow: one instruction at a time, taken only after the previous result beat is popped
// reset: all architectural state cleared; the data ram is zeroed by a pass over its
//   DataRamBytes/4 rows after reset, during which no result is produced
module rv32im_instruction_execute import rv32_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instruction_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] next_pc_o,
  output logic        reg_write_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic [1:0]  status_o,
  output logic [31:0] exit_value_o
);

  logic        inst_valid, inst_take;
  logic [31:0] inst;

  rv32_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full, .instruction_i,
    .inst_valid_o(inst_valid), .inst_take_i(inst_take), .inst_o(inst)
  );

  rv32_back u_back (
    .clk_i, .rst_ni, .inst_valid_i(inst_valid), .inst_i(inst), .inst_take_o(inst_take),
    .empty, .pop, .next_pc_o, .reg_write_o, .reg_index_o, .reg_value_o,
    .status_o, .exit_value_o
  );

endmodule
